// ----- hw/rtl/stk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack with bracket checker package
// Shared types, request codes, status codes and sizing constants.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int CHAR_W      = 8;

  typedef enum logic [2:0] {
    REQ_PUSH     = 3'd0,
    REQ_POP      = 3'd1,
    REQ_TOP      = 3'd2,
    REQ_IS_EMPTY = 3'd3,
    REQ_SIZE     = 3'd4,
    REQ_CLEAR    = 3'd5,
    REQ_BRACKET  = 3'd6
  } req_code_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_PAREN_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_PAREN_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_SQUARE_OPEN  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_SQUARE_CLOSE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_CURLY_OPEN  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_CURLY_CLOSE = 8'h7D;

  typedef struct packed {
    req_code_t                 req_type;
    logic signed [WORD_W-1:0]  push_value;
    logic [CHAR_W-1:0]         bracket_char;
    logic                      is_last_char;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [WORD_W-1:0]  result;
  } rsp_t;

  // Everything the execute stage decides for one transaction.
  typedef struct packed {
    logic                wr_en;
    logic [WORD_W-1:0]   wr_data;
    logic [CNT_W-1:0]    count_next;
    logic                failed_next;
    logic                has_rsp;
    rsp_t                rsp;
  } exec_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

// ----- hw/rtl/stack_with_bracket_checker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack with bracket checker
// Bounded LIFO of 32-bit words in a RAM, with push, pop, top, empty query,
// size, clear, and a balanced-bracket check that shares the same stack.
// ----------------------------------------------------------------------------
// Each transaction is accepted in S_IDLE and executed in S_EXEC: in the cycle
// it is accepted the RAM reads the current top entry, and in the next cycle the
// execute logic uses that word; it writes the RAM and updates the entry count
// as the transaction retires. A response sits in an output register; the
// block takes the next transaction while it waits, and only holds execution
// when a second response would overwrite one that is still stalled. The
// stack contents need no clearing after reset, so the block is ready at once.
module stack_with_bracket_checker_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  stk_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output stk_pkg::rsp_t rsp
);

  stk_pkg::state_t                 state;
  stk_pkg::state_t                 state_next;
  stk_pkg::req_t                   req_q;
  logic [stk_pkg::CNT_W-1:0]       count;
  logic                            failed;
  logic [stk_pkg::WORD_W-1:0]      top_word;
  stk_pkg::exec_t                  ex;
  logic                            accept;
  logic                            commit;
  logic                            commit_en;

  // A transaction without a response may retire even while the output stalls.
  assign commit = !ex.has_rsp || !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      stk_pkg::S_IDLE: if (req_valid) state_next = stk_pkg::S_EXEC;
      stk_pkg::S_EXEC: if (commit) state_next = stk_pkg::S_IDLE;
      default:         state_next = stk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    accept    = 1'b0;
    commit_en = 1'b0;
    unique case (state)
      stk_pkg::S_IDLE: begin
        req_stall = 1'b0;
        accept    = req_valid;
      end
      stk_pkg::S_EXEC: commit_en = commit;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stk_pkg::S_IDLE;
      count     <= '0;
      failed    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit_en) begin
        count  <= ex.count_next;
        failed <= ex.failed_next;
      end
      if (commit_en && ex.has_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (commit_en && ex.has_rsp) begin
      rsp <= ex.rsp;
    end
  end

  stk_mem #(
    .DEPTH (stk_pkg::STACK_DEPTH),
    .WIDTH (stk_pkg::WORD_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (commit_en && ex.wr_en),
    .wr_addr (count[stk_pkg::ADDR_W-1:0]),
    .wr_data (ex.wr_data),
    .rd_en   (accept),
    .rd_addr (count[stk_pkg::ADDR_W-1:0] - stk_pkg::ADDR_W'(1)),
    .rd_data (top_word)
  );

  stk_exec u_exec (
    .req      (req_q),
    .count    (count),
    .failed   (failed),
    .top_word (top_word),
    .ex       (ex)
  );

endmodule

// ----- hw/rtl/stk_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack storage RAM
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module stk_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/stk_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack execute logic
// Decides the memory write, the new count and failure flag, and the response
// for one transaction, given the word read from the top of the stack.
// ----------------------------------------------------------------------------
module stk_exec (
  input  stk_pkg::req_t                    req,
  input  logic [stk_pkg::CNT_W-1:0]        count,
  input  logic                             failed,
  input  logic [stk_pkg::WORD_W-1:0]       top_word,
  output stk_pkg::exec_t                   ex
);

  logic                        empty;
  logic                        full;
  logic                        is_opener;
  logic                        is_closer;
  logic [stk_pkg::CHAR_W-1:0]  want;
  logic [stk_pkg::CNT_W-1:0]   c_next;
  logic                        f_next;

  assign empty = (count == '0);
  assign full  = (count == stk_pkg::CNT_W'(stk_pkg::STACK_DEPTH));

  always_comb begin
    is_opener = 1'b0;
    is_closer = 1'b1;
    want      = stk_pkg::CH_PAREN_OPEN;
    case (req.bracket_char)
      stk_pkg::CH_PAREN_OPEN, stk_pkg::CH_SQUARE_OPEN, stk_pkg::CH_CURLY_OPEN: begin
        is_opener = 1'b1;
        is_closer = 1'b0;
      end
      stk_pkg::CH_PAREN_CLOSE:  want = stk_pkg::CH_PAREN_OPEN;
      stk_pkg::CH_SQUARE_CLOSE: want = stk_pkg::CH_SQUARE_OPEN;
      stk_pkg::CH_CURLY_CLOSE:  want = stk_pkg::CH_CURLY_OPEN;
      default:                  is_closer = 1'b0;
    endcase
  end

  always_comb begin
    c_next         = count;
    f_next         = failed;
    ex.wr_en       = 1'b0;
    ex.wr_data     = req.push_value;
    ex.count_next  = count;
    ex.failed_next = failed;
    ex.has_rsp     = 1'b1;
    ex.rsp.status  = stk_pkg::ST_OK;
    ex.rsp.result  = '0;
    unique case (req.req_type)
      stk_pkg::REQ_PUSH: begin
        if (full) begin
          ex.rsp.status = stk_pkg::ST_FULL;
        end else begin
          ex.wr_en      = 1'b1;
          ex.count_next = count + 1'b1;
          ex.rsp.result = req.push_value;
        end
      end
      stk_pkg::REQ_POP: begin
        if (empty) begin
          ex.rsp.status = stk_pkg::ST_EMPTY;
        end else begin
          ex.count_next = count - 1'b1;
          ex.rsp.result = top_word;
        end
      end
      stk_pkg::REQ_TOP: begin
        if (empty) begin
          ex.rsp.status = stk_pkg::ST_EMPTY;
        end else begin
          ex.rsp.result = top_word;
        end
      end
      stk_pkg::REQ_IS_EMPTY: ex.rsp.result = stk_pkg::WORD_W'(empty);
      stk_pkg::REQ_SIZE:     ex.rsp.result = stk_pkg::WORD_W'(count);
      stk_pkg::REQ_CLEAR:    ex.count_next = '0;
      stk_pkg::REQ_BRACKET: begin
        // Once a run has failed, later characters neither push nor pop.
        if (!failed) begin
          if (is_opener) begin
            if (full) begin
              f_next = 1'b1;
            end else begin
              ex.wr_en   = 1'b1;
              ex.wr_data = stk_pkg::WORD_W'(req.bracket_char);
              c_next     = count + 1'b1;
            end
          end else if (is_closer) begin
            if (empty) begin
              f_next = 1'b1;
            end else begin
              c_next = count - 1'b1;
              if (top_word != stk_pkg::WORD_W'(want)) begin
                f_next = 1'b1;
              end
            end
          end
        end
        if (req.is_last_char) begin
          ex.rsp.result  = (!f_next && c_next == '0) ? '0 : stk_pkg::WORD_W'(1);
          ex.count_next  = '0;
          ex.failed_next = 1'b0;
        end else begin
          ex.has_rsp     = 1'b0;
          ex.count_next  = c_next;
          ex.failed_next = f_next;
        end
      end
      default: ex.has_rsp = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/stk_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack with bracket checker port assertions
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module stk_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input stk_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input stk_pkg::rsp_t rsp
);

  // A stalled response stays on the port unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("response changed while stalled");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while previous one executes");

  // A new response only appears as an execution retires.
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without an executing transaction");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == stk_pkg::ST_OK || rsp.status == stk_pkg::ST_EMPTY ||
                   rsp.status == stk_pkg::ST_FULL))
    else $error("illegal status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != stk_pkg::ST_OK) |-> (rsp.result == '0))
    else $error("error response carries nonzero result");

endmodule

bind stack_with_bracket_checker_top stk_checker u_stk_checker (.*);
